// File: hdl/qvr_pkg.sv
package qvr_pkg;

  typedef enum logic [1:0] {
    QUAT_W = 2'd0,
    QUAT_X = 2'd1,
    QUAT_Y = 2'd2,
    QUAT_Z = 2'd3
  } quat_comp_e;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               saturated;
  } rot_t;

  localparam logic signed [31:0] QuatWReset = 32'sh4000_0000;

  localparam logic signed [31:0] RotMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RotMin = 32'sh8000_0000;

  // Per output component, the four terms of p * conj(q), signed as - + - +
  localparam quat_comp_e TermP [3][4] = '{
    '{QUAT_Y, QUAT_Z, QUAT_W, QUAT_X},
    '{QUAT_Z, QUAT_X, QUAT_W, QUAT_Y},
    '{QUAT_X, QUAT_Y, QUAT_W, QUAT_Z}
  };
  localparam quat_comp_e TermQ [3][4] = '{
    '{QUAT_Z, QUAT_Y, QUAT_X, QUAT_W},
    '{QUAT_X, QUAT_Z, QUAT_Y, QUAT_W},
    '{QUAT_Y, QUAT_X, QUAT_Z, QUAT_W}
  };

endpackage

// File: hdl/quaternion_vector_rotate.sv
// An accepted input passes through the product, sum, partial-product, partial-sum and output registers in turn.
// Throughput: one vector per cycle through a five-register multiply-add pipeline while the output is not stalled.
// A stall at the output holds each occupied stage; empty stages still advance.
// Reset clears all pipeline valid bits and loads the identity quaternion.
module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vec_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rot_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic signed [31:0] quat_q [4];
  logic [4:0]         vld_q;
  logic [4:0]         en;

  logic signed [63:0] m_d [12];
  logic signed [63:0] m_q [12];
  logic signed [65:0] p_d [4];
  logic signed [65:0] p_q [4];
  logic signed [65:0] hp_d [3][4];
  logic signed [65:0] hp_q [3][4];
  logic signed [64:0] lp_d [3][4];
  logic signed [64:0] lp_q [3][4];
  logic signed [67:0] hs_d [3];
  logic signed [67:0] hs_q [3];
  logic signed [66:0] ls_d [3];
  logic signed [66:0] ls_q [3];
  rot_t               out_d;
  rot_t               out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[QUAT_W] <= QuatWReset;
      quat_q[QUAT_X] <= '0;
      quat_q[QUAT_Y] <= '0;
      quat_q[QUAT_Z] <= '0;
    end else if (cfg_valid_i) begin
      case (quat_comp_e'(cfg_idx_i))
        QUAT_W:  quat_q[QUAT_W] <= cfg_data_i;
        QUAT_X:  quat_q[QUAT_X] <= cfg_data_i;
        QUAT_Y:  quat_q[QUAT_Y] <= cfg_data_i;
        QUAT_Z:  quat_q[QUAT_Z] <= cfg_data_i;
        default: quat_q[QUAT_W] <= quat_q[QUAT_W];
      endcase
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    en[4] = !vld_q[4] || out_ready_i;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[4];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < 5; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0: products of q * (0, v)
  always_comb begin
    m_d[0]  = 64'(quat_q[QUAT_X]) * 64'(in_data_i.vec_x);
    m_d[1]  = 64'(quat_q[QUAT_Y]) * 64'(in_data_i.vec_y);
    m_d[2]  = 64'(quat_q[QUAT_Z]) * 64'(in_data_i.vec_z);
    m_d[3]  = 64'(quat_q[QUAT_Y]) * 64'(in_data_i.vec_z);
    m_d[4]  = 64'(quat_q[QUAT_Z]) * 64'(in_data_i.vec_y);
    m_d[5]  = 64'(quat_q[QUAT_W]) * 64'(in_data_i.vec_x);
    m_d[6]  = 64'(quat_q[QUAT_Z]) * 64'(in_data_i.vec_x);
    m_d[7]  = 64'(quat_q[QUAT_X]) * 64'(in_data_i.vec_z);
    m_d[8]  = 64'(quat_q[QUAT_W]) * 64'(in_data_i.vec_y);
    m_d[9]  = 64'(quat_q[QUAT_X]) * 64'(in_data_i.vec_y);
    m_d[10] = 64'(quat_q[QUAT_Y]) * 64'(in_data_i.vec_x);
    m_d[11] = 64'(quat_q[QUAT_W]) * 64'(in_data_i.vec_z);
  end

  // stage 1: sums forming p
  always_comb begin
    p_d[QUAT_W] = -66'(m_q[0]) - 66'(m_q[1]) - 66'(m_q[2]);
    p_d[QUAT_X] = 66'(m_q[3]) - 66'(m_q[4]) + 66'(m_q[5]);
    p_d[QUAT_Y] = 66'(m_q[6]) - 66'(m_q[7]) + 66'(m_q[8]);
    p_d[QUAT_Z] = 66'(m_q[9]) - 66'(m_q[10]) + 66'(m_q[11]);
  end

  // stage 2: split p into high and low halves, multiply each by q
  always_comb begin
    logic signed [33:0] p_hi;
    logic signed [32:0] p_lo;
    for (int c = 0; c < 3; c++) begin
      for (int t = 0; t < 4; t++) begin
        p_hi     = p_q[TermP[c][t]][65:32];
        p_lo     = {1'b0, p_q[TermP[c][t]][31:0]};
        hp_d[c][t] = 66'(p_hi) * 66'(quat_q[TermQ[c][t]]);
        lp_d[c][t] = 65'(p_lo) * 65'(quat_q[TermQ[c][t]]);
      end
    end
  end

  // stage 3: signed sums of the partial products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      hs_d[c] = -68'(hp_q[c][0]) + 68'(hp_q[c][1]) - 68'(hp_q[c][2]) + 68'(hp_q[c][3]);
      ls_d[c] = -67'(lp_q[c][0]) + 67'(lp_q[c][1]) - 67'(lp_q[c][2]) + 67'(lp_q[c][3]);
    end
  end

  // stage 4: recombine halves, drop 60 fraction bits, saturate
  always_comb begin
    logic signed [100:0] tot;
    logic signed [40:0]  sh;
    logic signed [31:0]  res [3];
    logic [2:0]          sat;
    for (int c = 0; c < 3; c++) begin
      tot = (101'(hs_q[c]) <<< 32) + 101'(ls_q[c]);
      sh  = tot[100:60];
      if (sh > 41'(RotMax)) begin
        res[c] = RotMax;
        sat[c] = 1'b1;
      end else if (sh < 41'(RotMin)) begin
        res[c] = RotMin;
        sat[c] = 1'b1;
      end else begin
        res[c] = sh[31:0];
        sat[c] = 1'b0;
      end
    end
    out_d.rot_x     = res[0];
    out_d.rot_y     = res[1];
    out_d.rot_z     = res[2];
    out_d.saturated = |sat;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m_q <= m_d;
    end
    if (en[1]) begin
      p_q <= p_d;
    end
    if (en[2]) begin
      hp_q <= hp_d;
      lp_q <= lp_d;
    end
    if (en[3]) begin
      hs_q <= hs_d;
      ls_q <= ls_d;
    end
    if (en[4]) begin
      out_q <= out_d;
    end
  end

  a_ready_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o
  ) else $error("input stalled with empty output stage");

  a_accept_enters: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0]
  ) else $error("accepted transaction missing from first stage");

  a_sat_clips: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |->
      (out_data_o.rot_x == RotMax || out_data_o.rot_x == RotMin ||
       out_data_o.rot_y == RotMax || out_data_o.rot_y == RotMin ||
       out_data_o.rot_z == RotMax || out_data_o.rot_z == RotMin)
  ) else $error("saturation flag without a clipped component");

endmodule

// File: bench/rotate_checker.sv
`timescale 1ns / 100ps
module rotate_checker
  import qvr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  vec_t        in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rot_t        out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  logic signed [31:0] quat [4];
  rot_t               rotated_q [$];
  int unsigned        mismatches;

  function automatic rot_t rotate_vec(vec_t v);
    logic signed [127:0] qw, qx, qy, qz, vx, vy, vz, pw, px, py, pz;
    logic signed [127:0] acc [3];
    logic signed [63:0]  trunc;
    logic signed [31:0]  comp [3];
    rot_t                r;
    qw = 128'(quat[QUAT_W]);
    qx = 128'(quat[QUAT_X]);
    qy = 128'(quat[QUAT_Y]);
    qz = 128'(quat[QUAT_Z]);
    vx = 128'($signed(v.vec_x));
    vy = 128'($signed(v.vec_y));
    vz = 128'($signed(v.vec_z));
    pw = -(qx * vx) - qy * vy - qz * vz;
    px = qy * vz - qz * vy + qw * vx;
    py = qz * vx - qx * vz + qw * vy;
    pz = qx * vy - qy * vx + qw * vz;
    acc[0] = -(py * qz) + pz * qy - pw * qx + px * qw;
    acc[1] = -(pz * qx) + px * qz - pw * qy + py * qw;
    acc[2] = -(px * qy) + py * qx - pw * qz + pz * qw;
    r.saturated = 1'b0;
    for (int i = 0; i < 3; i++) begin
      // drop 60 fraction bits, floor toward minus infinity
      trunc = acc[i][123:60];
      if (trunc > 64'(RotMax)) begin
        comp[i] = RotMax;
        r.saturated = 1'b1;
      end else if (trunc < 64'(RotMin)) begin
        comp[i] = RotMin;
        r.saturated = 1'b1;
      end else begin
        comp[i] = trunc[31:0];
      end
    end
    r.rot_x = comp[0];
    r.rot_y = comp[1];
    r.rot_z = comp[2];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rot_t want;
    if (!rst_ni) begin
      quat[QUAT_W] = QuatWReset;
      quat[QUAT_X] = '0;
      quat[QUAT_Y] = '0;
      quat[QUAT_Z] = '0;
      rotated_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        quat[cfg_idx_i] = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (rotated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t mismatch: unexpected result x=%h y=%h z=%h sat=%b", $realtime,
                     out_data_i.rot_x, out_data_i.rot_y, out_data_i.rot_z,
                     out_data_i.saturated);
          end
        end else begin
          want = rotated_q.pop_front();
          if (out_data_i.rot_x !== want.rot_x || out_data_i.rot_y !== want.rot_y ||
              out_data_i.rot_z !== want.rot_z || out_data_i.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t mismatch: expected x=%h y=%h z=%h sat=%b", $realtime,
                       want.rot_x, want.rot_y, want.rot_z, want.saturated);
              $display("%0t           actual   x=%h y=%h z=%h sat=%b", $realtime,
                       out_data_i.rot_x, out_data_i.rot_y, out_data_i.rot_z,
                       out_data_i.saturated);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        rotated_q.push_back(rotate_vec(in_data_i));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= rotated_q.size();
  end

endmodule

// File: bench/tb_quaternion_vector_rotate.sv
`timescale 1ns / 100ps
module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  localparam int unsigned        StallLimit = 1000;
  localparam int unsigned        NumPhases  = 9;
  localparam int unsigned        PhaseItems = 100;
  localparam logic signed [31:0] FieldMax   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FieldMin   = 32'sh8000_0000;
  localparam logic signed [31:0] QuatOne    = 32'sh4000_0000;
  localparam logic signed [31:0] CosEighth  = 32'sh2D41_3CCD;
  localparam logic signed [31:0] UnitQ16    = 32'sh0001_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  vec_t        in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rot_t        out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned idle_cycles = 0;
  bit          send_burst  = 1'b0;
  bit          recv_burst  = 1'b0;

  quaternion_vector_rotate uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  rotate_checker u_rotate_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic vec_t mk_vec(logic signed [31:0] x, y, z);
    vec_t v;
    v.vec_x = x;
    v.vec_y = y;
    v.vec_z = z;
    return v;
  endfunction

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3:       return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      4:       return $urandom_range(0, 1) ? FieldMax : FieldMin;
      default: return int'($urandom_range(0, 4)) - 2;
    endcase
  endfunction

  function automatic vec_t rand_vec();
    return mk_vec(rand_field(), rand_field(), rand_field());
  endfunction

  // kind 0: components within +-0.5, kind 1: full range, otherwise extremes and zero
  function automatic logic signed [31:0] rand_quat_comp(int kind);
    case (kind)
      0: return int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 2))
          0:       return FieldMax;
          1:       return FieldMin;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic send_vec(input vec_t v);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off until every pending transaction has come out of the pipeline
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_quat(input logic signed [31:0] w, x, y, z);
    logic signed [31:0] vals  [4];
    quat_comp_e         comps [4];
    vals  = '{w, x, y, z};
    comps = '{QUAT_W, QUAT_X, QUAT_Y, QUAT_Z};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_idx_i   <= comps[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int kind;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_idx_i   = QUAT_W;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity quaternion out of reset
    send_vec(mk_vec(0, 0, 0));
    send_vec(mk_vec(FieldMax, FieldMax, FieldMax));
    send_vec(mk_vec(FieldMin, FieldMin, FieldMin));
    send_vec(mk_vec(1, -1, 0));
    send_vec(mk_vec(-1, -1, -1));
    send_vec(mk_vec(FieldMax, FieldMin, UnitQ16));
    send_vec(rand_vec());
    send_vec(rand_vec());

    // quarter turn about z
    drain();
    write_quat(CosEighth, 0, 0, CosEighth);
    send_vec(mk_vec(UnitQ16, 0, 0));
    send_vec(mk_vec(0, UnitQ16, 0));
    send_vec(mk_vec(-1, -1, -1));

    // largest non-unit quaternion, forces clipping
    drain();
    write_quat(FieldMax, FieldMax, FieldMax, FieldMax);
    send_vec(mk_vec(FieldMax, FieldMax, FieldMax));
    send_vec(mk_vec(FieldMin, FieldMin, FieldMin));
    send_vec(mk_vec(UnitQ16, 0, 0));

    drain();
    write_quat(FieldMin, FieldMin, FieldMin, FieldMin);
    send_vec(mk_vec(FieldMax, FieldMin, FieldMax));
    send_vec(mk_vec(UnitQ16, -UnitQ16, 1));

    drain();
    write_quat(0, 0, 0, 0);
    send_vec(mk_vec(FieldMax, FieldMin, -1));

    // half turn about x
    drain();
    write_quat(0, QuatOne, 0, 0);
    send_vec(mk_vec(UnitQ16, 2 * UnitQ16, 3 * UnitQ16));
    send_vec(mk_vec(FieldMin, FieldMax, -1));

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      if (ph == 0) begin
        write_quat(QuatOne, 0, 0, 0);
      end else begin
        kind = ph % 3;
        write_quat(rand_quat_comp(kind), rand_quat_comp(kind), rand_quat_comp(kind),
                   rand_quat_comp(kind));
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 59) == 0) drain();
        send_vec(rand_vec());
      end
    end

    drain();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
